FILE: rtl/assert_macros.svh
// Assertion helpers used by the decoder unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define LFB64_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define LFB64_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/lfb64_pkg.sv
`default_nettype none

package lfb64_pkg;

   localparam int LENGTH_LIMIT_BITS = 28;

   localparam int LEN_W   = 29;
   localparam int CHARS_W = 30;
   localparam int PROD_W  = LEN_W + 4;
   localparam int CMP_W   = CHARS_W + 3;

   localparam logic [LEN_W-1:0]   LEN_MAX   = '1;
   localparam logic [CHARS_W-1:0] CHARS_MAX = '1;
   localparam logic [63:0] LIMIT_FULL = 64'd1 << LENGTH_LIMIT_BITS;
   localparam logic [LEN_W-1:0] LIMIT_RESET =
      (LIMIT_FULL > 64'(LEN_MAX)) ? LEN_MAX : LIMIT_FULL[LEN_W-1:0];

   localparam logic [7:0] CHAR_DOT    = 8'h2E;
   localparam logic [7:0] CHAR_PLUS   = 8'h2B;
   localparam logic [7:0] CHAR_ZERO   = 8'h30;
   localparam logic [7:0] CHAR_NINE   = 8'h39;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;

   localparam logic [7:0] SYM_UPPER_BASE = 8'd1;
   localparam logic [7:0] SYM_LOWER_BASE = 8'd27;
   localparam logic [7:0] SYM_DIGIT_BASE = 8'd53;
   localparam logic [5:0] SYM_PLUS       = 6'd63;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_NO_PREFIX = 3'd1,
      ST_NOT_NUMBER = 3'd2,
      ST_TOO_LONG  = 3'd3,
      ST_TRUNCATED = 3'd4,
      ST_BAD_CHAR  = 3'd5
   } status_type;

   typedef struct packed {
      logic       valid;
      logic [7:0] char_code;
      logic       text_last;
   } item_type;

   typedef struct packed {
      logic       byte_valid;
      logic [7:0] data_byte;
      logic       text_done;
      status_type status;
   } result_type;

   // Bit 6 set: not a symbol of the alphabet. Bits 5:0: symbol value.
   function automatic logic [6:0] symbol_value(input logic [7:0] c);
      logic [6:0] v;
      case (c) inside
         CHAR_DOT:                     v = 7'd0;
         [CHAR_UPPER_A:CHAR_UPPER_Z]:  v = {1'b0, 6'(c - CHAR_UPPER_A + SYM_UPPER_BASE)};
         [CHAR_LOWER_A:CHAR_LOWER_Z]:  v = {1'b0, 6'(c - CHAR_LOWER_A + SYM_LOWER_BASE)};
         [CHAR_ZERO:CHAR_NINE]:        v = {1'b0, 6'(c - CHAR_ZERO + SYM_DIGIT_BASE)};
         CHAR_PLUS:                    v = {1'b0, SYM_PLUS};
         default:                      v = {1'b1, 6'd0};
      endcase
      return v;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/lfb64_if.sv
`default_nettype none

interface lfb64_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;
   logic       text_last;
   modport source (output valid, output char_code, output text_last, input ready);
   modport sink (input valid, input char_code, input text_last, output ready);
endinterface

interface lfb64_rsp_if;
   logic                   valid;
   logic                   ready;
   logic                   byte_valid;
   logic [7:0]             data_byte;
   logic                   text_done;
   lfb64_pkg::status_type  status;
   modport source (output valid, output byte_valid, output data_byte, output text_done,
                   output status, input ready);
   modport sink (input valid, input byte_valid, input data_byte, input text_done,
                 input status, output ready);
endinterface

interface lfb64_csr_if;
   logic                        valid;
   logic                        ready;
   logic [lfb64_pkg::LEN_W-1:0] length_limit;
   modport source (output valid, output length_limit, input ready);
   modport sink (input valid, input length_limit, output ready);
endinterface

`default_nettype wire

FILE: rtl/lfb64_in_stage.sv
`default_nettype none

// Input register: holds one character beat until the core consumes it.
module lfb64_in_stage (
   input  wire logic         clock,
   input  wire logic         reset,
   lfb64_req_if.sink         req_bus,
   input  wire logic         consume,
   output lfb64_pkg::item_type item
);

   logic       valid_ff;
   logic [7:0] char_ff;
   logic       last_ff;
   logic       take;

   assign req_bus.ready = !valid_ff || consume;
   assign take = req_bus.valid && req_bus.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (take) begin
         valid_ff <= 1'b1;
      end else if (consume) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         char_ff <= req_bus.char_code;
         last_ff <= req_bus.text_last;
      end
   end

   assign item.valid     = valid_ff;
   assign item.char_code = char_ff;
   assign item.text_last = last_ff;

endmodule

`default_nettype wire

FILE: rtl/lfb64_core.sv
`default_nettype none

// Per-character decode: prefix parse, symbol packing, error latch, final status.
module lfb64_core (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire lfb64_pkg::item_type          item,
   input  wire logic                         out_free,
   input  wire logic                         csr_write,
   input  wire logic [lfb64_pkg::LEN_W-1:0]  csr_data,
   output logic                              consume,
   output logic                              rsp_load,
   output lfb64_pkg::result_type             result
);

   logic [lfb64_pkg::LEN_W-1:0]   limit_ff;
   logic                          in_body_ff, in_body_in;
   logic [lfb64_pkg::LEN_W-1:0]   decl_ff, decl_in;
   logic                          digit_seen_ff, digit_seen_in;
   lfb64_pkg::status_type         pend_ff, pend_in;
   logic [7:0]                    partial_ff, partial_in;
   logic [2:0]                    fill_ff, fill_in;
   logic [lfb64_pkg::LEN_W-1:0]   emitted_ff, emitted_in;
   logic [lfb64_pkg::CHARS_W-1:0] chars_ff, chars_in;

   logic                          got_byte;
   logic [7:0]                    byte_out;
   logic [6:0]                    sym;
   logic                          is_digit;
   logic [lfb64_pkg::PROD_W-1:0]  prod;
   logic [13:0]                   merged;
   logic [lfb64_pkg::LEN_W-1:0]   emitted_inc;
   logic [lfb64_pkg::CMP_W-1:0]   lhs, rhs, diff;
   logic                          count_match;
   lfb64_pkg::status_type         final_status;

   assign sym      = lfb64_pkg::symbol_value(item.char_code);
   assign is_digit = (item.char_code >= lfb64_pkg::CHAR_ZERO) &&
                     (item.char_code <= lfb64_pkg::CHAR_NINE);
   // count * 10 + digit, as count * 8 + count * 2
   assign prod = {1'b0, decl_ff, 3'b000} + {3'b000, decl_ff, 1'b0}
               + lfb64_pkg::PROD_W'(item.char_code - lfb64_pkg::CHAR_ZERO);
   assign merged      = {6'd0, partial_ff} | ({8'd0, sym[5:0]} << fill_ff);
   assign emitted_inc = emitted_ff + lfb64_pkg::LEN_W'(1);

   always_comb begin
      in_body_in    = in_body_ff;
      decl_in       = decl_ff;
      digit_seen_in = digit_seen_ff;
      pend_in       = pend_ff;
      partial_in    = partial_ff;
      fill_in       = fill_ff;
      emitted_in    = emitted_ff;
      chars_in      = chars_ff;
      got_byte      = 1'b0;
      byte_out      = 8'd0;
      if (!in_body_ff) begin
         if (item.char_code == lfb64_pkg::CHAR_DOT) begin
            in_body_in = 1'b1;
            if (!digit_seen_ff && pend_ff == lfb64_pkg::ST_OK) begin
               pend_in = lfb64_pkg::ST_NO_PREFIX;
            end
         end else if (pend_ff == lfb64_pkg::ST_OK) begin
            if (!is_digit) begin
               pend_in = lfb64_pkg::ST_NOT_NUMBER;
            end else begin
               digit_seen_in = 1'b1;
               if (prod > {4'd0, limit_ff}) begin
                  pend_in = lfb64_pkg::ST_TOO_LONG;
               end else begin
                  decl_in = prod[lfb64_pkg::LEN_W-1:0];
               end
            end
         end
      end else begin
         if (chars_ff != lfb64_pkg::CHARS_MAX) begin
            chars_in = chars_ff + lfb64_pkg::CHARS_W'(1);
         end
         if (sym[6]) begin
            if (pend_ff == lfb64_pkg::ST_OK) begin
               pend_in = lfb64_pkg::ST_BAD_CHAR;
            end
         end else if (pend_ff == lfb64_pkg::ST_OK && emitted_ff < decl_ff) begin
            if (fill_ff < 3'd2) begin
               partial_in = merged[7:0];
               fill_in    = fill_ff + 3'd6;
            end else begin
               got_byte   = 1'b1;
               byte_out   = merged[7:0];
               emitted_in = emitted_inc;
               if (emitted_inc >= decl_ff) begin
                  // count reached: drop the rest of this symbol
                  partial_in = 8'd0;
                  fill_in    = 3'd0;
               end else begin
                  partial_in = {2'b00, merged[13:8]};
                  fill_in    = fill_ff - 3'd2;
               end
            end
         end
      end
   end

   // Body length check: chars == ceil(4 * count / 3), i.e. 0 <= 4*count + 2 - 3*chars <= 2
   assign lhs  = {2'b00, decl_in, 2'b00} + lfb64_pkg::CMP_W'(2);
   assign rhs  = {2'b00, chars_in, 1'b0} + {3'b000, chars_in};
   assign diff = lhs - rhs;
   assign count_match = (lhs >= rhs) && (diff <= lfb64_pkg::CMP_W'(2));

   always_comb begin
      if (!in_body_in) begin
         final_status = lfb64_pkg::ST_NO_PREFIX;
      end else if (pend_in == lfb64_pkg::ST_NO_PREFIX || pend_in == lfb64_pkg::ST_NOT_NUMBER ||
                   pend_in == lfb64_pkg::ST_TOO_LONG) begin
         final_status = pend_in;
      end else if (!count_match) begin
         final_status = lfb64_pkg::ST_TRUNCATED;
      end else if (pend_in == lfb64_pkg::ST_BAD_CHAR) begin
         final_status = lfb64_pkg::ST_BAD_CHAR;
      end else begin
         final_status = lfb64_pkg::ST_OK;
      end
   end

   assign consume  = item.valid && (!(got_byte || item.text_last) || out_free);
   assign rsp_load = consume && (got_byte || item.text_last);

   assign result.byte_valid = got_byte;
   assign result.data_byte  = byte_out;
   assign result.text_done  = item.text_last;
   assign result.status     = item.text_last ? final_status : lfb64_pkg::ST_OK;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= lfb64_pkg::LIMIT_RESET;
      end else if (csr_write) begin
         limit_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (consume && item.text_last)) begin
         in_body_ff    <= 1'b0;
         decl_ff       <= '0;
         digit_seen_ff <= 1'b0;
         pend_ff       <= lfb64_pkg::ST_OK;
         partial_ff    <= 8'd0;
         fill_ff       <= 3'd0;
         emitted_ff    <= '0;
         chars_ff      <= '0;
      end else if (consume) begin
         in_body_ff    <= in_body_in;
         decl_ff       <= decl_in;
         digit_seen_ff <= digit_seen_in;
         pend_ff       <= pend_in;
         partial_ff    <= partial_in;
         fill_ff       <= fill_in;
         emitted_ff    <= emitted_in;
         chars_ff      <= chars_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/lfb64_out_stage.sv
`default_nettype none

// Result register: holds one result beat until the sink takes it.
module lfb64_out_stage (
   input  wire logic                   clock,
   input  wire logic                   reset,
   lfb64_rsp_if.source                 rsp_bus,
   input  wire logic                   load,
   input  wire lfb64_pkg::result_type  data,
   output logic                        out_free
);

   logic                  valid_ff;
   lfb64_pkg::result_type data_ff;

   assign out_free = !valid_ff || rsp_bus.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= data;
      end
   end

   assign rsp_bus.valid      = valid_ff;
   assign rsp_bus.byte_valid = data_ff.byte_valid;
   assign rsp_bus.data_byte  = data_ff.data_byte;
   assign rsp_bus.text_done  = data_ff.text_done;
   assign rsp_bus.status     = data_ff.status;

endmodule

`default_nettype wire

FILE: rtl/lsb_first_base64_decoder_unit.sv
// Length-prefixed, LSB-first base64 text decoder. Feed one character per req beat; a text is
// a decimal byte count, a '.', then body characters from the alphabet '.', A-Z, a-z, 0-9, '+'
// (values 0 to 63), with text_last on its final character. Each symbol contributes six bits,
// packed least significant first; a rsp beat carries each byte as soon as it completes, up to
// the declared count, and the final character always yields a rsp beat with text_done and the
// status (0 ok, 1 no prefix, 2 not number, 3 too long, 4 truncated, 5 bad character). A text
// that ends with a nonzero status must have its already delivered bytes discarded. The csr
// port sets the largest accepted count (reset value 2^28); write it only while idle. Timing:
// one character per clock sustained; a req beat passes the input register, then the result
// register; the rate is set by the single-cycle update of the decode state, and a stalled
// rsp side holds the req side once both registers are full.
`default_nettype none
`include "assert_macros.svh"

module lsb_first_base64_decoder_unit (
   input  wire logic    clock,
   input  wire logic    reset,
   lfb64_req_if.sink    req_bus,
   lfb64_rsp_if.source  rsp_bus,
   lfb64_csr_if.sink    csr_bus
);

   lfb64_pkg::item_type   item;
   lfb64_pkg::result_type result;
   logic                  consume;
   logic                  rsp_load;
   logic                  out_free;

   // Register is always writable; each write is registered into the length limit.
   assign csr_bus.ready = 1'b1;

   // Hold the incoming character beat.
   lfb64_in_stage u_in_stage (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .consume (consume),
      .item    (item)
   );

   // Advance decode state and build the result for the held character.
   lfb64_core u_core (
      .clock     (clock),
      .reset     (reset),
      .item      (item),
      .out_free  (out_free),
      .csr_write (csr_bus.valid && csr_bus.ready),
      .csr_data  (csr_bus.length_limit),
      .consume   (consume),
      .rsp_load  (rsp_load),
      .result    (result)
   );

   // Hold the result beat until taken.
   lfb64_out_stage u_out_stage (
      .clock    (clock),
      .reset    (reset),
      .rsp_bus  (rsp_bus),
      .load     (rsp_load),
      .data     (result),
      .out_free (out_free)
   );

   // A beat without text_done exists only because a byte completed.
   `LFB64_ASSERT_NOW(a_rsp_has_cause, clock, reset, rsp_bus.valid && !rsp_bus.text_done, rsp_bus.byte_valid, "result beat carries neither byte nor status")
   // Status is zero unless the text ends.
   `LFB64_ASSERT_NOW(a_status_on_done, clock, reset, rsp_bus.valid && !rsp_bus.text_done, rsp_bus.status == lfb64_pkg::ST_OK, "status set before end of text")
   // Data byte is zero when no byte is carried.
   `LFB64_ASSERT_NOW(a_byte_zero, clock, reset, rsp_bus.valid && !rsp_bus.byte_valid, rsp_bus.data_byte == 8'd0, "data byte set without byte_valid")
   // A loaded result shows up on the rsp side next cycle.
   `LFB64_ASSERT_NEXT(a_load_shows, clock, reset, rsp_load, rsp_bus.valid, "loaded result not presented")

endmodule

`default_nettype wire
